// ===== design/sad_pkg.sv =====
package sad_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 32;
	localparam int UCNT_W    = 7;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ITEMS);

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic [UCNT_W-1:0]       count;
		logic                    overflow;
	} res_t;

endpackage

// ===== design/sad_ram.sv =====
module sad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sad_ctrl.sv =====
module sad_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sad_pkg::VAL_W-1:0] in_value,
	input  logic                          in_last,
	output logic                          mem_we,
	output logic [sad_pkg::ADDR_W-1:0]    mem_waddr,
	output logic [sad_pkg::VAL_W-1:0]     mem_wdata,
	output logic                          mem_re,
	output logic [sad_pkg::ADDR_W-1:0]    mem_raddr,
	input  logic [sad_pkg::VAL_W-1:0]     mem_rdata,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sad_pkg::res_t                 res
);

	import sad_pkg::*;

	typedef enum logic [5:0] {
		ST_LOAD     = 6'b000001,
		ST_SORT     = 6'b000010,
		ST_FLUSH    = 6'b000100,
		ST_EMIT_RD  = 6'b001000,
		ST_EMIT_CMP = 6'b010000,
		ST_EMIT_FIN = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    dropped_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        pass_q;
	logic [CNT_W-1:0]        uniq_q;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [VAL_W-1:0] pend_q;
	logic                    vld_s1;
	logic [CNT_W-1:0]        idx_s1;

	logic                    in_acc;
	logic signed [VAL_W-1:0] rd_val;
	logic signed [VAL_W-1:0] lo_val;
	logic signed [VAL_W-1:0] hi_val;
	logic [CNT_W-1:0]        idx_m1;
	logic [CNT_W-1:0]        fill_m1;
	logic                    first_el;
	logic                    differ;
	logic                    last_el;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign rd_val   = $signed(mem_rdata);
	assign lo_val   = (rd_val < carry_q) ? rd_val : carry_q;
	assign hi_val   = (rd_val < carry_q) ? carry_q : rd_val;
	assign idx_m1   = idx_s1 - CNT_W'(1);
	assign fill_m1  = fill_q - CNT_W'(1);
	assign first_el = (idx_q == '0);
	assign differ   = !first_el && (rd_val != pend_q);
	assign last_el  = (idx_q == fill_m1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[ADDR_W-1:0];
		mem_wdata = in_value;
		mem_re    = 1'b0;
		mem_raddr = idx_q[ADDR_W-1:0];
		res_valid = 1'b0;
		res.value    = pend_q;
		res.last     = 1'b0;
		res.count    = '0;
		res.overflow = dropped_q;
		case (state_q)
			ST_LOAD: begin
				mem_we = in_acc && (fill_q < FULL_CNT);
			end
			ST_SORT: begin
				mem_re = (idx_q < fill_q);
				if (vld_s1 && idx_s1 != '0) begin
					mem_we    = 1'b1;
					mem_waddr = idx_m1[ADDR_W-1:0];
					mem_wdata = lo_val;
				end
			end
			ST_FLUSH: begin
				mem_we    = 1'b1;
				mem_waddr = fill_m1[ADDR_W-1:0];
				mem_wdata = carry_q;
			end
			ST_EMIT_RD: begin
				mem_re = 1'b1;
			end
			ST_EMIT_CMP: begin
				res_valid = differ && res_ready;
			end
			ST_EMIT_FIN: begin
				res_valid = res_ready;
				res.last  = 1'b1;
				res.count = UCNT_W'(uniq_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			fill_q    <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
			pass_q    <= '0;
			uniq_q    <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (fill_q < FULL_CNT) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (in_last) begin
							idx_q   <= '0;
							pass_q  <= '0;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (idx_q < fill_q) begin
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + CNT_W'(1);
					end
					if (vld_s1 && idx_s1 == fill_m1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					idx_q  <= '0;
					pass_q <= pass_q + CNT_W'(1);
					if (pass_q == fill_m1) begin
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_SORT;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CMP;
				end
				ST_EMIT_CMP: begin
					if (!differ || res_ready) begin
						if (first_el) begin
							uniq_q <= CNT_W'(1);
						end else if (differ) begin
							uniq_q <= uniq_q + CNT_W'(1);
						end
						if (last_el) begin
							state_q <= ST_EMIT_FIN;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_FIN: begin
					if (res_ready) begin
						fill_q    <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// sort datapath: carry holds the running maximum of a bubble pass; pend holds the previous value during emit
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (state_q == ST_SORT && vld_s1) begin
			carry_q <= (idx_s1 == '0) ? rd_val : hi_val;
		end
		if (state_q == ST_EMIT_CMP && (!differ || res_ready)) begin
			pend_q <= rd_val;
		end
	end

endmodule

// ===== design/sort_and_deduplicate.sv =====
// load: one element per cycle while s_tready is high; elements beyond the store
// depth are dropped; after the last element: n bubble passes through the element
// memory, then a read and a compare per stored element, then the final transaction
// reset: arst_n asynchronous, clears control state; memory contents not cleared
module sort_and_deduplicate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // value_res
	output logic        m_tlast,  // last_res
	output logic [7:0]  m_tuser   // overflow (bit 7), unique_count (bits 6:0)
);

	import sad_pkg::*;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [VAL_W-1:0]  mem_rdata;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	sad_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  ($signed(s_tdata)),
		.in_last   (s_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tlast  = out_q.last;
	assign m_tuser  = {out_q.overflow, out_q.count};

	a_res_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result produced with output register full");

	a_no_load_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("result produced while loading");

	a_count_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[6:0] == '0)
		else $error("unique count on a non-final transaction");

	a_last_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[6:0] != '0)
		else $error("final transaction with zero unique count");

endmodule
